### design/ice_maker_supervisor_macros.svh
// Assertion helpers shared by the supervisor RTL.
`ifndef ICE_MAKER_SUPERVISOR_MACROS_SVH
`define ICE_MAKER_SUPERVISOR_MACROS_SVH

// Checks a property on every rising edge of clk while reset is released.
`define IMS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same check, taken only on cycles where the qualifier is high.
`define IMS_ASSERT_WHEN(label, qual, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (qual) |-> (prop)) \
        else $error(msg);

`endif

### design/ims_pkg.sv
package ims_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_PUMP_TIMEOUT  = 3'd0;
    localparam logic [2:0] REG_COOLDOWN      = 3'd1;
    localparam logic [2:0] REG_DEFROST       = 3'd2;
    localparam logic [2:0] REG_BIN_PAUSE     = 3'd3;
    localparam logic [2:0] REG_BIN_DELAY     = 3'd4;
    localparam logic [2:0] REG_INRUSH_GRACE  = 3'd5;
    localparam logic [2:0] REG_CURRENT_LIMIT = 3'd6;
    localparam logic [2:0] REG_IR_THRESHOLD  = 3'd7;

    // Configuration reset values.
    localparam logic [31:0] RST_PUMP_TIMEOUT  = 32'd60000;
    localparam logic [31:0] RST_COOLDOWN      = 32'd180000;
    localparam logic [31:0] RST_DEFROST       = 32'd300000;
    localparam logic [31:0] RST_BIN_PAUSE     = 32'd600000;
    localparam logic [31:0] RST_BIN_DELAY     = 32'd5000;
    localparam logic [31:0] RST_INRUSH_GRACE  = 32'd2000;
    localparam logic [15:0] RST_CURRENT_LIMIT = 16'd1500;
    localparam logic [9:0]  RST_IR_THRESHOLD  = 10'd512;

    // Panel button codes.
    localparam logic [1:0] BTN_IDLE  = 2'd0;
    localparam logic [1:0] BTN_POWER = 2'd1;
    localparam logic [1:0] BTN_LIGHT = 2'd2;
    localparam logic [1:0] BTN_OTHER = 2'd3;

    // Bit positions in the actuator latch word.
    localparam int LAT_PUMP     = 0;
    localparam int LAT_UV       = 1;
    localparam int LAT_COMP     = 2;
    localparam int LAT_FAN      = 3;
    localparam int LAT_AUGER    = 4;
    localparam int LAT_BINLIGHT = 5;

    typedef struct packed {
        logic [31:0] pump_timeout_ms;
        logic [31:0] cooldown_ms;
        logic [31:0] defrost_ms;
        logic [31:0] bin_pause_ms;
        logic [31:0] bin_delay_ms;
        logic [31:0] inrush_grace_ms;
        logic [15:0] current_limit_ma;
        logic [9:0]  ir_threshold;
    } cfg_t;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        float_full;
        logic        float_empty;
        logic        bin_inserted;
        logic [9:0]  ir_level;
        logic [15:0] auger_current_ma;
        logic        button_valid;
        logic [1:0]  button_code;
    } tick_t;

    typedef struct packed {
        logic [5:0] latches;
        logic [4:0] panel_lights;
        logic       halted;
    } res_t;

    typedef struct packed {
        logic        powered;
        logic        light_on;
        logic        empty_halt;
        logic        defrosting;
        logic        bin_is_full;
        logic        pump_running;
        logic        comp_running;
        logic        cooldown_pending;
        logic        bin_checking;
        logic [31:0] pump_start_at;
        logic [31:0] comp_stop_at;
        logic [31:0] comp_start_at;
        logic [31:0] defrost_start_at;
        logic [31:0] bin_check_at;
        logic [31:0] bin_full_at;
        logic [1:0]  last_button;
        logic [5:0]  latches;
    } sup_state_t;

endpackage

### design/ims_cfg_regs.sv
module ims_cfg_regs
    import ims_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        cfg_ready,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // The register file takes a write in every cycle.
    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // Decode the index and replace the addressed register.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_PUMP_TIMEOUT:  cfg_next.pump_timeout_ms  = cfg_data;
                REG_COOLDOWN:      cfg_next.cooldown_ms      = cfg_data;
                REG_DEFROST:       cfg_next.defrost_ms       = cfg_data;
                REG_BIN_PAUSE:     cfg_next.bin_pause_ms     = cfg_data;
                REG_BIN_DELAY:     cfg_next.bin_delay_ms     = cfg_data;
                REG_INRUSH_GRACE:  cfg_next.inrush_grace_ms  = cfg_data;
                REG_CURRENT_LIMIT: cfg_next.current_limit_ma = cfg_data[15:0];
                REG_IR_THRESHOLD:  cfg_next.ir_threshold     = cfg_data[9:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pump_timeout_ms  <= RST_PUMP_TIMEOUT;
            cfg_reg.cooldown_ms      <= RST_COOLDOWN;
            cfg_reg.defrost_ms       <= RST_DEFROST;
            cfg_reg.bin_pause_ms     <= RST_BIN_PAUSE;
            cfg_reg.bin_delay_ms     <= RST_BIN_DELAY;
            cfg_reg.inrush_grace_ms  <= RST_INRUSH_GRACE;
            cfg_reg.current_limit_ma <= RST_CURRENT_LIMIT;
            cfg_reg.ir_threshold     <= RST_IR_THRESHOLD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### design/ims_tick_logic.sv
module ims_tick_logic
    import ims_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  advance,
    input  tick_t tick,
    input  cfg_t  cfg,
    output res_t  res
);

`include "ice_maker_supervisor_macros.svh"

    sup_state_t st_reg;
    sup_state_t st_next;

    logic [31:0] now;
    logic        seen;
    logic        halt;
    logic        done;

    assign now = tick.now_ms;

    // One control tick: button, then the halted branch or the run rules in order.
    always_comb
    begin
        st_next = st_reg;
        halt    = 1'b0;
        done    = 1'b0;
        seen    = (tick.ir_level >= cfg.ir_threshold);

        // A fresh button reading is applied once per change of code.
        if (tick.button_valid && (tick.button_code != st_reg.last_button))
        begin
            if (tick.button_code == BTN_POWER)
            begin
                st_next.powered    = !st_reg.powered;
                st_next.empty_halt = 1'b0;
            end
            else if (tick.button_code == BTN_LIGHT)
            begin
                st_next.light_on              = !st_reg.light_on;
                st_next.latches[LAT_BINLIGHT] = !st_reg.light_on;
            end
            st_next.last_button = tick.button_code;
        end

        if (!st_next.powered || st_next.empty_halt || st_next.defrosting
            || st_next.bin_is_full)
        begin
            // Halted: drop every drive but the bin light and let timers expire.
            halt            = 1'b1;
            st_next.latches = st_next.latches & (6'd1 << LAT_BINLIGHT);
            st_next.pump_running = 1'b0;
            if (st_next.comp_running)
            begin
                st_next.comp_stop_at     = now;
                st_next.comp_running     = 1'b0;
                st_next.cooldown_pending = 1'b1;
            end
            if (!tick.bin_inserted)
            begin
                st_next.empty_halt   = 1'b0;
                st_next.bin_is_full  = 1'b0;
                st_next.bin_checking = 1'b0;
            end
            if (st_next.defrosting
                && ((now - st_next.defrost_start_at) > cfg.defrost_ms))
            begin
                st_next.defrosting = 1'b0;
            end
            if (st_next.bin_is_full
                && ((now - st_next.bin_full_at) > cfg.bin_pause_ms))
            begin
                st_next.bin_is_full = 1'b0;
            end
        end
        else
        begin
            // Pumping too long means the supply tank ran dry.
            if (st_next.pump_running
                && ((now - st_next.pump_start_at) > cfg.pump_timeout_ms))
            begin
                st_next.empty_halt = 1'b1;
                done               = 1'b1;
            end

            if (!done)
            begin
                // Float hysteresis on the reservoir.
                if (tick.float_empty && !st_next.pump_running)
                begin
                    st_next.latches[LAT_PUMP] = 1'b1;
                    st_next.latches[LAT_UV]   = 1'b1;
                    st_next.pump_running      = 1'b1;
                    st_next.pump_start_at     = now;
                end
                else if (tick.float_full && st_next.pump_running)
                begin
                    st_next.latches[LAT_PUMP] = 1'b0;
                    st_next.latches[LAT_UV]   = 1'b0;
                    st_next.pump_running      = 1'b0;
                end

                // A blocked beam held long enough marks the bin full.
                if (seen)
                begin
                    st_next.bin_checking = 1'b0;
                end
                else if (!st_next.bin_checking)
                begin
                    st_next.bin_checking = 1'b1;
                    st_next.bin_check_at = now;
                end
                else if ((now - st_next.bin_check_at) > cfg.bin_delay_ms)
                begin
                    st_next.bin_is_full = 1'b1;
                    st_next.bin_full_at = now;
                    done                = 1'b1;
                end
            end

            // Compressor start waits for cooldown and a clear beam.
            if (!done && !st_next.comp_running)
            begin
                if (st_next.cooldown_pending)
                begin
                    if ((now - st_next.comp_stop_at) < cfg.cooldown_ms)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        st_next.cooldown_pending = 1'b0;
                    end
                end
                if (!done && st_next.bin_checking)
                begin
                    done = 1'b1;
                end
                if (!done)
                begin
                    st_next.latches[LAT_COMP]  = 1'b1;
                    st_next.latches[LAT_FAN]   = 1'b1;
                    st_next.latches[LAT_AUGER] = 1'b1;
                    st_next.comp_start_at      = now;
                    st_next.comp_running       = 1'b1;
                end
            end

            // Auger overcurrent after the inrush window means a jam.
            if (!done && (tick.auger_current_ma >= cfg.current_limit_ma)
                && ((now - st_next.comp_start_at) > cfg.inrush_grace_ms))
            begin
                st_next.defrosting       = 1'b1;
                st_next.defrost_start_at = now;
            end
        end

        res.latches      = st_next.latches;
        res.panel_lights = {st_reg.comp_running, st_reg.light_on, st_reg.empty_halt,
                            st_reg.defrosting, st_reg.powered};
        res.halted       = halt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (advance)
        begin
            st_reg <= st_next;
        end
    end

    // The run flags and the drive latches move together.
    `IMS_ASSERT(a_pump_latch, st_reg.pump_running == st_reg.latches[LAT_PUMP], "pump vs latch")
    `IMS_ASSERT(a_comp_latch, st_reg.comp_running == st_reg.latches[LAT_AUGER], "comp vs latch")
    `IMS_ASSERT_WHEN(a_cool_idle, st_reg.cooldown_pending, !st_reg.comp_running, "cool while on")

endmodule

### design/ice_maker_supervisor.sv
// Ice-maker supervisor.
// Input channel: one beat per control tick (timestamp, float and bin switches,
// IR level, auger current and panel button), handshake in_valid / in_stall.
// Output channel: one beat per tick with the actuator drives, the panel lights
// and the halted flag, handshake out_valid / out_stall.
// Configuration channel: cfg_valid / cfg_ready with a register index and data;
// cfg_ready is always high; writes must be made while no tick is in flight,
// which the block does not enforce. An accepted tick goes through the input
// register and then the result register. A tick is taken every cycle unless
// in_stall is high: the rules run in one pass of combinational logic between
// the two, and the state is updated as the tick enters the result register.
// When the receiver stalls, the result holds and the input register still
// loads; in_stall rises only when both registers are full and the result is
// stalled.
// Reset clears all flags, time stamps and drives and reloads the register
// defaults; no tick is pending after reset.
module ice_maker_supervisor
    import ims_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] now_ms,
    input  logic        float_full,
    input  logic        float_empty,
    input  logic        bin_inserted,
    input  logic [9:0]  ir_level,
    input  logic [15:0] auger_current_ma,
    input  logic        button_valid,
    input  logic [1:0]  button_code,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        pump_on,
    output logic        uv_on,
    output logic        compressor_on,
    output logic        fan_on,
    output logic        auger_on,
    output logic        bin_light_on,
    output logic [4:0]  panel_lights,
    output logic        halted
);

`include "ice_maker_supervisor_macros.svh"

    cfg_t  cfg;
    tick_t tick_reg;
    logic  tick_vld_reg;
    logic  tick_vld_next;
    res_t  res;
    res_t  res_reg;
    logic  res_vld_reg;
    logic  res_vld_next;
    logic  res_free;
    logic  advance;
    logic  take;
    logic  drives_idle;
    logic  followers_ok;

    ims_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .cfg       (cfg)
    );

    ims_tick_logic u_tick (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .tick    (tick_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // Pipeline flow: the result register frees up when its beat is taken.
    assign res_free = !res_vld_reg || !out_stall;
    assign advance  = tick_vld_reg && res_free;
    assign in_stall = tick_vld_reg && !res_free;
    assign take     = in_valid && !in_stall;

    assign tick_vld_next = take || (tick_vld_reg && !advance);
    assign res_vld_next  = advance || (res_vld_reg && !res_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            tick_vld_reg <= tick_vld_next;
            res_vld_reg  <= res_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            tick_reg <= '{now_ms, float_full, float_empty, bin_inserted, ir_level,
                          auger_current_ma, button_valid, button_code};
        end
        if (advance)
        begin
            res_reg <= res;
        end
    end

    // Result beat fields.
    assign out_valid     = res_vld_reg;
    assign pump_on       = res_reg.latches[LAT_PUMP];
    assign uv_on         = res_reg.latches[LAT_UV];
    assign compressor_on = res_reg.latches[LAT_COMP];
    assign fan_on        = res_reg.latches[LAT_FAN];
    assign auger_on      = res_reg.latches[LAT_AUGER];
    assign bin_light_on  = res_reg.latches[LAT_BINLIGHT];
    assign panel_lights  = res_reg.panel_lights;
    assign halted        = res_reg.halted;

    assign drives_idle  = !pump_on && !compressor_on && !auger_on;
    assign followers_ok = (uv_on == pump_on) && (fan_on == compressor_on);

    // A halted tick leaves only the bin light driven; follower drives track.
    `IMS_ASSERT_WHEN(a_halt_drives, out_valid && halted, drives_idle, "drive on halted beat")
    `IMS_ASSERT_WHEN(a_followers, out_valid, followers_ok, "follower drive out of step")
    `IMS_ASSERT_WHEN(a_no_loss, in_stall, ##1 tick_vld_reg, "pending tick dropped under stall")

endmodule

### test/tb.sv
module tb;
    import ims_pkg::*;

    localparam int WATCHDOG_CYCLES = 2000;

    localparam cfg_t FACTORY_LIMITS = {RST_PUMP_TIMEOUT, RST_COOLDOWN, RST_DEFROST,
                                       RST_BIN_PAUSE, RST_BIN_DELAY, RST_INRUSH_GRACE,
                                       RST_CURRENT_LIMIT, RST_IR_THRESHOLD};
    localparam cfg_t ZERO_LIMITS = '0;
    localparam cfg_t MAX_LIMITS = '1;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] now_ms = '0;
    logic        float_full = 1'b0;
    logic        float_empty = 1'b0;
    logic        bin_inserted = 1'b0;
    logic [9:0]  ir_level = '0;
    logic [15:0] auger_current_ma = '0;
    logic        button_valid = 1'b0;
    logic [1:0]  button_code = BTN_IDLE;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        pump_on;
    logic        uv_on;
    logic        compressor_on;
    logic        fan_on;
    logic        auger_on;
    logic        bin_light_on;
    logic [4:0]  panel_lights;
    logic        halted;

    // Supervisor state and register copy kept by the predictor.
    sup_state_t plant;
    cfg_t       limits;

    tick_t pending_ticks [$];
    res_t  due_results [$];

    logic        no_idling = 1'b0;
    logic [31:0] clock_ms;
    logic        water_low;
    logic        water_high;
    logic        beam_blocked;
    string       drive_name [6];

    int ticks_sent;
    int results_checked;
    int fails;
    int quiet_cycles;
    int halted_ticks;
    int comp_starts;
    int empty_halts;
    int bins_full;
    int jams;

    ice_maker_supervisor dut (.*);

    // Clock with a period of 10.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] ms_since(input logic [31:0] now, input logic [31:0] stamp);
        return now - stamp;
    endfunction

    // One control tick of the supervisor: returns the result beat and advances the state.
    function automatic res_t predict_tick(input tick_t t);
        res_t r;
        logic seen;
        logic done;
        r.panel_lights = {plant.comp_running, plant.light_on, plant.empty_halt,
                          plant.defrosting, plant.powered};
        r.halted = 1'b0;
        done = 1'b0;

        // A button counts only when it differs from the last one applied.
        if (t.button_valid && t.button_code != plant.last_button)
        begin
            if (t.button_code == BTN_POWER)
            begin
                plant.powered = !plant.powered;
                plant.empty_halt = 1'b0;
            end
            else if (t.button_code == BTN_LIGHT)
            begin
                plant.light_on = !plant.light_on;
                plant.latches[LAT_BINLIGHT] = plant.light_on;
            end
            plant.last_button = t.button_code;
        end

        seen = t.ir_level >= limits.ir_threshold;

        // Halted branch: everything but the bin light drops, timers may clear the halt.
        if (!plant.powered || plant.empty_halt || plant.defrosting || plant.bin_is_full)
        begin
            plant.latches = plant.latches & (6'd1 << LAT_BINLIGHT);
            plant.pump_running = 1'b0;
            if (plant.comp_running)
            begin
                plant.comp_stop_at = t.now_ms;
                plant.comp_running = 1'b0;
                plant.cooldown_pending = 1'b1;
            end
            if (!t.bin_inserted)
            begin
                plant.empty_halt = 1'b0;
                plant.bin_is_full = 1'b0;
                plant.bin_checking = 1'b0;
            end
            if (plant.defrosting &&
                ms_since(t.now_ms, plant.defrost_start_at) > limits.defrost_ms)
                plant.defrosting = 1'b0;
            if (plant.bin_is_full && ms_since(t.now_ms, plant.bin_full_at) > limits.bin_pause_ms)
                plant.bin_is_full = 1'b0;
            r.halted = 1'b1;
            done = 1'b1;
            halted_ticks++;
        end

        // Pumping too long means the tank ran dry.
        if (!done && plant.pump_running &&
            ms_since(t.now_ms, plant.pump_start_at) > limits.pump_timeout_ms)
        begin
            plant.empty_halt = 1'b1;
            done = 1'b1;
            empty_halts++;
        end

        // Float hysteresis, then the blocked-beam timing for a full bin.
        if (!done)
        begin
            if (t.float_empty && !plant.pump_running)
            begin
                plant.latches[LAT_PUMP] = 1'b1;
                plant.latches[LAT_UV] = 1'b1;
                plant.pump_running = 1'b1;
                plant.pump_start_at = t.now_ms;
            end
            else if (t.float_full && plant.pump_running)
            begin
                plant.latches[LAT_PUMP] = 1'b0;
                plant.latches[LAT_UV] = 1'b0;
                plant.pump_running = 1'b0;
            end
            if (seen)
                plant.bin_checking = 1'b0;
            else if (!plant.bin_checking)
            begin
                plant.bin_checking = 1'b1;
                plant.bin_check_at = t.now_ms;
            end
            else if (ms_since(t.now_ms, plant.bin_check_at) > limits.bin_delay_ms)
            begin
                plant.bin_is_full = 1'b1;
                plant.bin_full_at = t.now_ms;
                done = 1'b1;
                bins_full++;
            end
        end

        // Compressor restart waits out the cooldown and a clear beam.
        if (!done && !plant.comp_running)
        begin
            if (plant.cooldown_pending)
            begin
                if (ms_since(t.now_ms, plant.comp_stop_at) < limits.cooldown_ms)
                    done = 1'b1;
                else
                    plant.cooldown_pending = 1'b0;
            end
            if (!done && plant.bin_checking)
                done = 1'b1;
            if (!done)
            begin
                plant.latches[LAT_COMP] = 1'b1;
                plant.latches[LAT_FAN] = 1'b1;
                plant.latches[LAT_AUGER] = 1'b1;
                plant.comp_start_at = t.now_ms;
                plant.comp_running = 1'b1;
                comp_starts++;
            end
        end

        // Auger jam once the inrush grace is over.
        if (!done && t.auger_current_ma >= limits.current_limit_ma &&
            ms_since(t.now_ms, plant.comp_start_at) > limits.inrush_grace_ms)
        begin
            plant.defrosting = 1'b1;
            plant.defrost_start_at = t.now_ms;
            jams++;
        end

        r.latches = plant.latches;
        return r;
    endfunction

    // Input driver: offers queued ticks, holds them while stalled, idles in bursts.
    always @(posedge clk or negedge rst_n)
    begin : feed_ticks
        tick_t on_bus;
        tick_t next_tick;
        int gap_left;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                on_bus = {now_ms, float_full, float_empty, bin_inserted, ir_level,
                          auger_current_ma, button_valid, button_code};
                due_results.push_back(predict_tick(on_bus));
                ticks_sent++;
            end
            if (!(in_valid && in_stall))
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_ticks.size() != 0 && !no_idling &&
                         $urandom_range(0, 15) == 0)
                begin
                    gap_left = $urandom_range(0, 13);
                    in_valid <= 1'b0;
                end
                else if (pending_ticks.size() != 0)
                begin
                    next_tick = pending_ticks.pop_front();
                    {now_ms, float_full, float_empty, bin_inserted, ir_level,
                     auger_current_ma, button_valid, button_code} <= next_tick;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: checks each accepted beat against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : check_results
        res_t got;
        res_t want;
        string bad;
        int stall_left;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got.latches[LAT_PUMP] = pump_on;
                got.latches[LAT_UV] = uv_on;
                got.latches[LAT_COMP] = compressor_on;
                got.latches[LAT_FAN] = fan_on;
                got.latches[LAT_AUGER] = auger_on;
                got.latches[LAT_BINLIGHT] = bin_light_on;
                got.panel_lights = panel_lights;
                got.halted = halted;
                if (due_results.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("result beat with no tick waiting: %b %b %b",
                                 got.latches, got.panel_lights, got.halted);
                end
                else
                begin
                    want = due_results.pop_front();
                    bad = "";
                    for (int b = 0; b < 6; b++)
                        if (got.latches[b] !== want.latches[b])
                            bad = {bad, " ", drive_name[b]};
                    if (got.panel_lights !== want.panel_lights)
                        bad = {bad, " panel_lights"};
                    if (got.halted !== want.halted)
                        bad = {bad, " halted"};
                    if (bad != "")
                    begin
                        fails++;
                        if (fails <= 10)
                        begin
                            $display("result %0d wrong in%s:", results_checked, bad);
                            $display("  expected drives=%b lights=%b halted=%b",
                                     want.latches, want.panel_lights, want.halted);
                            $display("  actual   drives=%b lights=%b halted=%b",
                                     got.latches, got.panel_lights, got.halted);
                        end
                    end
                end
                results_checked++;
            end

            // Receiver stalls in bursts, started at random unless no_idling is set.
            if (stall_left != 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!no_idling && $urandom_range(0, 15) == 0)
            begin
                stall_left = $urandom_range(0, 13);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog: ends the run when no beat moves on any channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("watchdog: no beat for %0d cycles, %0d results still due",
                     quiet_cycles, due_results.size());
            $display("** ice_maker_supervisor: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic push_tick(input logic [31:0] now, input logic full, input logic empty,
                             input logic bin, input logic [9:0] ir, input logic [15:0] cur,
                             input logic bv, input logic [1:0] code);
        pending_ticks.push_back({now, full, empty, bin, ir, cur, bv, code});
    endtask

    // Ticks from a plausible machine: advancing time, slow floats and beam, rare buttons.
    task automatic queue_ticks(input int count, input int step_max, input int noise_pct);
        tick_t t;
        for (int i = 0; i < count; i++)
        begin
            clock_ms += $urandom_range(0, step_max);
            if ($urandom_range(0, 63) == 0)
                clock_ms = $urandom();
            if ($urandom_range(0, 5) == 0)
                water_low = !water_low;
            if ($urandom_range(0, 5) == 0)
                water_high = !water_high;
            if ($urandom_range(0, 9) == 0)
                beam_blocked = !beam_blocked;
            t.now_ms = clock_ms;
            t.float_empty = water_low;
            t.float_full = water_high;
            t.bin_inserted = ($urandom_range(0, 29) != 0);
            if (beam_blocked && limits.ir_threshold != 0)
                t.ir_level = 10'($urandom_range(0, limits.ir_threshold - 1));
            else
                t.ir_level = 10'($urandom_range(limits.ir_threshold, 1023));
            if ($urandom_range(0, 11) == 0 || limits.current_limit_ma == 0)
                t.auger_current_ma = 16'($urandom_range(limits.current_limit_ma, 16'hFFFF));
            else
                t.auger_current_ma = 16'($urandom_range(0, limits.current_limit_ma - 1));
            t.button_valid = ($urandom_range(0, 4) != 0);
            case ($urandom_range(0, 99))
                0: t.button_code = BTN_POWER;
                1, 2, 3: t.button_code = BTN_LIGHT;
                4, 5: t.button_code = BTN_OTHER;
                default: t.button_code = BTN_IDLE;
            endcase
            // Some ticks are pure noise on every field.
            if ($urandom_range(0, 99) < noise_pct)
                t = {$urandom(), $urandom()};
            pending_ticks.push_back(t);
        end
    endtask

    function automatic cfg_t small_limits();
        cfg_t c;
        c.pump_timeout_ms = $urandom_range(0, 200);
        c.cooldown_ms = $urandom_range(0, 200);
        c.defrost_ms = $urandom_range(0, 300);
        c.bin_pause_ms = $urandom_range(0, 300);
        c.bin_delay_ms = $urandom_range(0, 100);
        c.inrush_grace_ms = $urandom_range(0, 50);
        c.current_limit_ma = 16'($urandom());
        c.ir_threshold = 10'($urandom());
        return c;
    endfunction

    // Waits until every tick has gone in and every result has come out.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_ticks.size() != 0 || in_valid || due_results.size() != 0);
        @(posedge clk);
    endtask

    // Writes all eight registers back to back; upper data bits of the two narrow registers carry junk.
    task automatic program_limits(input cfg_t c);
        logic [31:0] word [8];
        logic [31:0] junk;
        junk = $urandom();
        word[REG_PUMP_TIMEOUT] = c.pump_timeout_ms;
        word[REG_COOLDOWN] = c.cooldown_ms;
        word[REG_DEFROST] = c.defrost_ms;
        word[REG_BIN_PAUSE] = c.bin_pause_ms;
        word[REG_BIN_DELAY] = c.bin_delay_ms;
        word[REG_INRUSH_GRACE] = c.inrush_grace_ms;
        word[REG_CURRENT_LIMIT] = {junk[31:16], c.current_limit_ma};
        word[REG_IR_THRESHOLD] = {junk[31:10], c.ir_threshold};
        for (int i = 0; i < 8; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= i[2:0];
            cfg_data <= word[i];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        limits = c;
    endtask

    // Sequence of the run: reset, directed ticks, then random phases per register setting.
    initial
    begin
        drive_name[LAT_PUMP] = "pump_on";
        drive_name[LAT_UV] = "uv_on";
        drive_name[LAT_COMP] = "compressor_on";
        drive_name[LAT_FAN] = "fan_on";
        drive_name[LAT_AUGER] = "auger_on";
        drive_name[LAT_BINLIGHT] = "bin_light_on";
        plant = '0;
        limits = FACTORY_LIMITS;
        water_low = 1'b0;
        water_high = 1'b0;
        beam_blocked = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Unpowered tick with no button, then power on with an empty tank.
        push_tick(32'd0, 1'b0, 1'b0, 1'b1, 10'd1023, 16'd0, 1'b0, BTN_IDLE);
        push_tick(32'd10, 1'b0, 1'b1, 1'b1, 10'd1023, 16'd0, 1'b1, BTN_POWER);
        // Power held: the same code again changes nothing.
        push_tick(32'd20, 1'b0, 1'b1, 1'b1, 10'd1023, 16'd0, 1'b1, BTN_POWER);
        // Full auger current inside the inrush grace is ignored.
        push_tick(32'd1000, 1'b0, 1'b1, 1'b1, 10'd600, 16'hFFFF, 1'b1, BTN_IDLE);
        // Light button; upper float stops the pump.
        push_tick(32'd2000, 1'b1, 1'b0, 1'b1, 10'd600, 16'd0, 1'b1, BTN_LIGHT);
        // Beam exactly at threshold, current one below the limit.
        push_tick(32'd2100, 1'b0, 1'b0, 1'b1, 10'd512, 16'd1499, 1'b1, BTN_OTHER);
        // Current at the limit after the grace: auger jam, defrost.
        push_tick(32'd5000, 1'b0, 1'b0, 1'b1, 10'd1023, 16'd1500, 1'b1, BTN_IDLE);
        push_tick(32'd6000, 1'b0, 1'b0, 1'b1, 10'd1023, 16'd0, 1'b0, BTN_IDLE);
        // Defrost runs out, then the compressor restarts after its cooldown.
        push_tick(32'd306011, 1'b0, 1'b0, 1'b1, 10'd1023, 16'd0, 1'b0, BTN_IDLE);
        push_tick(32'd306020, 1'b0, 1'b0, 1'b1, 10'd1023, 16'd0, 1'b0, BTN_IDLE);
        // Pump runs past its timeout: empty-tank halt.
        push_tick(32'd306030, 1'b0, 1'b1, 1'b1, 10'd1023, 16'd0, 1'b0, BTN_IDLE);
        push_tick(32'd366031, 1'b0, 1'b1, 1'b1, 10'd1023, 16'd0, 1'b0, BTN_IDLE);
        push_tick(32'd366040, 1'b0, 1'b1, 1'b1, 10'd1023, 16'd0, 1'b0, BTN_IDLE);
        // Power off and on again; the cooldown then blocks the restart.
        push_tick(32'd366050, 1'b0, 1'b0, 1'b1, 10'd1023, 16'd0, 1'b1, BTN_POWER);
        push_tick(32'd366060, 1'b0, 1'b0, 1'b1, 10'd1023, 16'd0, 1'b1, BTN_IDLE);
        push_tick(32'd366070, 1'b0, 1'b0, 1'b1, 10'd1023, 16'd0, 1'b1, BTN_POWER);
        push_tick(32'd546040, 1'b0, 1'b0, 1'b1, 10'd1023, 16'd0, 1'b1, BTN_IDLE);
        // Beam blocked past the delay: bin full, then the bin is pulled.
        push_tick(32'd546050, 1'b0, 1'b0, 1'b1, 10'd0, 16'd0, 1'b1, BTN_IDLE);
        push_tick(32'd551051, 1'b0, 1'b0, 1'b1, 10'd0, 16'd0, 1'b1, BTN_IDLE);
        push_tick(32'd551060, 1'b0, 1'b0, 1'b0, 10'd0, 16'd0, 1'b1, BTN_IDLE);
        // Pump timeout measured across the wrap of the timestamp.
        push_tick(32'hFFFF_FFF0, 1'b0, 1'b1, 1'b1, 10'd1023, 16'd0, 1'b1, BTN_IDLE);
        push_tick(32'd60000, 1'b0, 1'b1, 1'b1, 10'd1023, 16'd0, 1'b1, BTN_IDLE);
        push_tick(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 10'd1023, 16'hFFFF, 1'b1, BTN_OTHER);
        clock_ms = 32'd60000;
        wait_drained();

        program_limits(small_limits());
        queue_ticks(250, 30, 10);
        wait_drained();

        program_limits(ZERO_LIMITS);
        queue_ticks(80, 30, 10);
        wait_drained();

        program_limits(MAX_LIMITS);
        queue_ticks(80, 30, 15);
        wait_drained();

        program_limits(small_limits());
        queue_ticks(350, 30, 10);
        wait_drained();

        // Last part at the factory settings, with no idling on either side.
        program_limits(FACTORY_LIMITS);
        no_idling <= 1'b1;
        queue_ticks(170, 70000, 5);
        wait_drained();
        repeat (8) @(posedge clk);
        fails += due_results.size();

        $display("Covered %0d ticks over six register settings: %0d halted, %0d starts,",
                 ticks_sent, halted_ticks, comp_starts);
        $display("%0d empty halts, %0d full bins, %0d jams; %0d checked, %0d bad.",
                 empty_halts, bins_full, jams, results_checked, fails);
        if (fails == 0)
            $display("** ice_maker_supervisor: PASSED **");
        else
            $display("** ice_maker_supervisor: FAILED **");
        $finish;
    end

endmodule
